### src/fgln_pkg.sv
// ----------------------------------------------------------------------------
// fgln_pkg
// Shared constants and types of the film grain luma noise block.
// ----------------------------------------------------------------------------
package fgln_pkg;

   localparam int LUMA_W = 8;
   localparam int SEED_W = 32;
   localparam int BITS_W = 12;
   localparam int GAIN_W = 11;

   localparam int QUEUE_DEPTH_DEF = 2;

   // generator
   localparam logic [15:0]       LEHMER_MULT  = 16'd48271;
   localparam logic [SEED_W-1:0] DEFAULT_SEED = 32'd123456789;
   localparam logic [GAIN_W-1:0] GAIN_RESET   = 11'd52;

   // inverse gaussian approximation
   localparam logic [15:0] MAP_MULT  = 16'd62259;
   localparam logic [15:0] MAP_ROUND = 16'd1638;
   localparam logic [15:0] Q_CENTER  = 16'd2048;
   localparam logic [15:0] NUM_MULT  = 16'd34757;
   localparam logic [15:0] NUM_BIAS  = 16'd9897;
   localparam logic [15:0] DEN_MULT  = 16'd49855;
   localparam logic [15:0] DEN_BIAS  = 16'd8657;
   localparam logic [15:0] V_OFFSET  = 16'd5591;

   // divider: numerator magnitude and denominator magnitude widths
   localparam int QUO_W     = 23;
   localparam int DVS_W     = 16;
   localparam int DIV_STEPS = QUO_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef struct packed {
      logic [BITS_W-1:0] bits;
      logic [LUMA_W-1:0] luma;
   } entry_type;

endpackage

### src/fgln_front.sv
// ----------------------------------------------------------------------------
// fgln_front
// Accepts pixels, reseeds and advances the Lehmer generator, queues the work.
// ----------------------------------------------------------------------------
module fgln_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic                       frame_start,
   input  logic [fgln_pkg::SEED_W-1:0] frame_seed,
   input  logic [fgln_pkg::LUMA_W-1:0] luma_in,
   output logic                       q_push,
   output fgln_pkg::entry_type        q_entry,
   input  logic                       q_full
);
   import fgln_pkg::*;

   typedef enum logic {F_IDLE, F_FOLD} state_type;

   state_type         state_ff, state_in;
   logic [SEED_W-1:0] gen_ff, gen_in;
   logic [47:0]       prod_ff, prod_in;
   logic [LUMA_W-1:0] luma_ff, luma_in_nx;

   logic [SEED_W-1:0] seed_use;
   logic [SEED_W-1:0] base;
   logic [31:0]       fold1;
   logic [31:0]       fold2;

   always_comb begin
      seed_use   = (frame_seed == '0) ? DEFAULT_SEED : frame_seed;
      base       = frame_start ? seed_use : gen_ff;
      // double fold of the product modulo 2^31-1
      fold1      = {1'b0, prod_ff[30:0]} + {15'b0, prod_ff[47:31]};
      fold2      = {1'b0, fold1[30:0]} + {31'b0, fold1[31]};
      full       = (state_ff != F_IDLE);
      q_push     = (state_ff == F_FOLD) && !q_full;
      q_entry.bits = fold2[BITS_W-1:0];
      q_entry.luma = luma_ff;
      state_in   = state_ff;
      gen_in     = gen_ff;
      prod_in    = prod_ff;
      luma_in_nx = luma_ff;
      case (state_ff)
         F_IDLE: begin
            if (push) begin
               prod_in    = {16'b0, base} * {32'b0, LEHMER_MULT};
               luma_in_nx = luma_in;
               state_in   = F_FOLD;
            end
         end
         F_FOLD: begin
            if (!q_full) begin
               gen_in   = fold2;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         gen_ff   <= DEFAULT_SEED;
      end else begin
         state_ff <= state_in;
         gen_ff   <= gen_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      luma_ff <= luma_in_nx;
   end

endmodule

### src/fgln_queue.sv
// ----------------------------------------------------------------------------
// fgln_queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module fgln_queue #(
   parameter int DEPTH = fgln_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fgln_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output fgln_pkg::entry_type pop_entry,
   output logic                empty
);
   import fgln_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   always_comb begin
      full      = (cnt_ff == CNT_W'(DEPTH));
      empty     = (cnt_ff == '0);
      do_push   = push && !full;
      do_pop    = pop && !empty;
      pop_entry = slot_ff[rd_ff];
      wr_in     = wr_ff;
      rd_in     = rd_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

### src/fgln_back.sv
// ----------------------------------------------------------------------------
// fgln_back
// Maps random bits to gaussian grain, scales it and adds it to the pixel.
// ----------------------------------------------------------------------------
module fgln_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [fgln_pkg::GAIN_W-1:0] gain,
   input  fgln_pkg::entry_type         q_entry,
   input  logic                        q_empty,
   output logic                        q_pop,
   output logic                        empty,
   input  logic                        pop,
   output logic [fgln_pkg::LUMA_W-1:0] luma_out
);
   import fgln_pkg::*;

   typedef enum logic [3:0] {
      B_IDLE, B_MAP, B_SQ, B_POLY, B_RAT, B_DIV, B_QUOT, B_SCALE, B_GAIN, B_SUM
   } state_type;

   state_type          state_ff, state_in;
   logic               out_valid_ff, out_valid_in;
   logic [LUMA_W-1:0]  out_luma_ff, out_luma_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic [BITS_W-1:0]  bits_ff, bits_in;
   logic [LUMA_W-1:0]  luma_ff, luma_in;
   logic signed [12:0] q_ff, q_in;
   logic [10:0]        s_ff, s_in;
   logic [20:0]        ss_ff, ss_in;
   logic [25:0]        pa_ff, pa_in;
   logic [25:0]        pb_ff, pb_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [DVS_W-1:0]   rem_ff, rem_in;
   logic [DVS_W-1:0]   dvs_ff, dvs_in;
   logic               neg_ff, neg_in;
   logic signed [15:0] v_ff, v_in;
   logic signed [15:0] w_ff, w_in;
   logic signed [11:0] g_ff, g_in;

   logic [27:0]        map_sum;
   logic [25:0]        sq;
   logic signed [26:0] num_x, num_t;
   logic signed [27:0] den_x, den_t;
   logic [DVS_W:0]     rem_sh;
   logic signed [23:0] qt;
   logic signed [28:0] vq, vq_t;
   logic signed [27:0] vg, vg_t;
   logic signed [12:0] sum;
   logic               out_free;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !pop;
      out_luma_in  = out_luma_ff;
      cnt_in       = cnt_ff;
      bits_in      = bits_ff;
      luma_in      = luma_ff;
      q_in         = q_ff;
      s_in         = s_ff;
      ss_in        = ss_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      neg_in       = neg_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      g_in         = g_ff;
      q_pop        = 1'b0;
      out_free     = !out_valid_ff || pop;

      map_sum = {16'b0, bits_ff} * {12'b0, MAP_MULT} + {12'b0, MAP_ROUND};
      sq      = {{13{q_ff[12]}}, q_ff} * {{13{q_ff[12]}}, q_ff};
      num_x   = $signed(27'(NUM_BIAS)) - $signed({1'b0, pa_ff});
      num_t   = (num_x < 0) ? (num_x + 27'sd15) >>> 4 : num_x >>> 4;
      den_x   = $signed({3'b0, ss_ff, 4'b0}) + $signed(28'(DEN_BIAS))
                - $signed({2'b0, pb_ff});
      den_t   = (den_x < 0) ? (den_x + 28'sd65535) >>> 16 : den_x >>> 16;
      rem_sh  = {rem_ff, quo_ff[QUO_W-1]};
      qt      = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      vq      = $signed({{13{v_ff[15]}}, v_ff}) * $signed({{16{q_ff[12]}}, q_ff});
      vq_t    = (vq < 0) ? (vq + 29'sd16383) >>> 14 : vq >>> 14;
      vg      = $signed({{12{w_ff[15]}}, w_ff}) * $signed({17'b0, gain});
      vg_t    = (vg < 0) ? (vg + 28'sd16383) >>> 14 : vg >>> 14;
      sum     = $signed({5'b0, luma_ff}) + $signed({g_ff[11], g_ff});

      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               bits_in  = q_entry.bits;
               luma_in  = q_entry.luma;
               state_in = B_MAP;
            end
         end
         B_MAP: begin
            q_in     = $signed({1'b0, map_sum[27:16]}) - $signed(13'(Q_CENTER));
            state_in = B_SQ;
         end
         B_SQ: begin
            s_in     = sq[22:12];
            state_in = B_POLY;
         end
         B_POLY: begin
            ss_in    = {10'b0, s_ff} * {10'b0, s_ff};
            pa_in    = {15'b0, s_ff} * {10'b0, NUM_MULT};
            pb_in    = {15'b0, s_ff} * {10'b0, DEN_MULT};
            state_in = B_RAT;
         end
         B_RAT: begin
            // zero denominator is taken as one
            quo_in   = (num_t < 0) ? QUO_W'(-num_t) : QUO_W'(num_t);
            if (den_t == 0) begin
               dvs_in = DVS_W'(1);
            end else begin
               dvs_in = (den_t < 0) ? DVS_W'(-den_t) : DVS_W'(den_t);
            end
            neg_in   = num_t[26] ^ den_t[27];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = B_DIV;
         end
         B_DIV: begin
            // restoring division, one quotient bit per cycle
            if (rem_sh >= {1'b0, dvs_ff}) begin
               rem_in = DVS_W'(rem_sh - {1'b0, dvs_ff});
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[DVS_W-1:0];
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = B_QUOT;
            end
         end
         B_QUOT: begin
            v_in     = 16'(qt + $signed(24'(V_OFFSET)));
            state_in = B_SCALE;
         end
         B_SCALE: begin
            w_in     = 16'(vq_t);
            state_in = B_GAIN;
         end
         B_GAIN: begin
            g_in     = 12'(vg_t);
            state_in = B_SUM;
         end
         B_SUM: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (sum < 0) begin
                  out_luma_in = '0;
               end else if (sum > 13'sd255) begin
                  out_luma_in = '1;
               end else begin
                  out_luma_in = sum[LUMA_W-1:0];
               end
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign empty    = !out_valid_ff;
   assign luma_out = out_luma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      out_luma_ff <= out_luma_in;
      bits_ff     <= bits_in;
      luma_ff     <= luma_in;
      q_ff        <= q_in;
      s_ff        <= s_in;
      ss_ff       <= ss_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      neg_ff      <= neg_in;
      v_ff        <= v_in;
      w_ff        <= w_in;
      g_ff        <= g_in;
   end

endmodule

### src/film_grain_luma_noise_top.sv
// ----------------------------------------------------------------------------
// film_grain_luma_noise_top
// Adds Lehmer-generator driven gaussian film grain to a luma pixel stream.
//
//   channel   direction  handshake             payload
//   request   in         push / full           req_frame_start, req_frame_seed,
//                                              req_luma_in
//   response  out        empty / pop           rsp_luma_out
//   csr       in         csr_valid / csr_ready csr_wdata (noise gain)
//
// The front end takes a pixel, multiplies, then folds the generator, and takes
// no new pixel until the folded item is in the queue. The back end runs the
// restoring divider of the rational approximation, which sets the rate, and
// takes a new pixel only after the last one is summed. Reset is synchronous
// and needs no clearing. A result not popped stalls the back end, the queue
// then fills and full holds off the front end.
// ----------------------------------------------------------------------------
module film_grain_luma_noise_top #(
   parameter int QUEUE_DEPTH = fgln_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic                        req_frame_start,
   input  logic [fgln_pkg::SEED_W-1:0] req_frame_seed,
   input  logic [fgln_pkg::LUMA_W-1:0] req_luma_in,
   output logic                        empty,
   input  logic                        pop,
   output logic [fgln_pkg::LUMA_W-1:0] rsp_luma_out,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [fgln_pkg::GAIN_W-1:0] csr_wdata
);
   import fgln_pkg::*;

   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic              q_push, q_full, q_pop, q_empty;
   entry_type         push_entry, pop_entry;

   assign csr_ready = 1'b1;
   assign gain_in   = (csr_valid && csr_ready) ? csr_wdata : gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
   end

   fgln_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .frame_start (req_frame_start),
      .frame_seed  (req_frame_seed),
      .luma_in     (req_luma_in),
      .q_push      (q_push),
      .q_entry     (push_entry),
      .q_full      (q_full)
   );

   fgln_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .empty      (q_empty)
   );

   fgln_back u_back (
      .clock    (clock),
      .reset    (reset),
      .gain     (gain_ff),
      .q_entry  (pop_entry),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .luma_out (rsp_luma_out)
   );

   // front end never pushes into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("push into full queue");

   // back end never pops an empty queue
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("pop from empty queue");

   // an accepted transaction keeps the front end busy in the fold state
   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> full) else $error("front end took back-to-back items");

   // gain changes only through the csr port
   a_gain_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_valid |=> $stable(gain_ff)) else $error("gain changed without write");

endmodule
